### hdl/integer_pixel_upscaler_unit_macros.svh
// ----------------------------------------------------------------------------
// Integer pixel upscaler assertion macros
// Shared concurrent assertion forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef INTEGER_PIXEL_UPSCALER_UNIT_MACROS_SVH
`define INTEGER_PIXEL_UPSCALER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define IPU_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define IPU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/ipu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Integer pixel upscaler package
// Sizes, codes and beat types shared by the upscaler and its checker.
// ----------------------------------------------------------------------------
package ipu_pkg;

  localparam int MAX_ROW_PIXELS = 2048;
  localparam int MAX_SCALE      = 100;
  localparam int PAD_ALIGN      = 4;

  localparam int ADDR_W  = $clog2(MAX_ROW_PIXELS);
  localparam int COL_W   = ADDR_W + 1;
  localparam int SCALE_W = 7;
  localparam int WIDTH_W = 12;
  localparam int PAD_W   = $clog2(PAD_ALIGN);
  localparam int PIX_W   = 24;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 12;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SCALE_FACTOR = 1'b0,
    REG_ROW_WIDTH    = 1'b1
  } reg_idx_t;

  typedef enum logic {
    OP_PIXEL = 1'b0,
    OP_TICK  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    KIND_PIXEL   = 2'd0,
    KIND_PAD     = 2'd1,
    KIND_REFUSED = 2'd2
  } kind_t;

  typedef struct packed {
    op_t        operation;
    logic [7:0] blue_in;
    logic [7:0] green_in;
    logic [7:0] red_in;
  } in_item_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] blue_out;
    logic [7:0] green_out;
    logic [7:0] red_out;
    logic       row_end;
    logic       expansion_end;
  } out_item_t;

  // Result description that waits in the read stage for the line buffer read data.
  typedef struct packed {
    kind_t kind;
    logic  use_mem;
    logic  row_end;
    logic  expansion_end;
  } res_meta_t;

endpackage

### hdl/integer_pixel_upscaler_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Integer pixel upscaler
// Nearest-neighbor row upscaler built around a single-port line buffer.
// ----------------------------------------------------------------------------
// Usage: program scale_factor (index 0) and row_width (index 1) on the cfg
// channel while the block is idle; cfg_ready is always high. Each input beat
// is either a pixel (operation 0) or a tick (operation 1). Pixels fill the
// line buffer; when row_width pixels have arrived the block switches to
// emitting and each tick yields one output beat: a replicated pixel or a
// zero pad byte, with row_end and expansion_end marking the row and the
// whole expansion. A pixel that arrives while emitting is answered with a
// refused beat. Ticks during loading and loaded pixels give no output beat.
// Pipeline: an accepted beat registers its line buffer read and its result
// description in the read stage, then moves into the output register when
// that register is empty or being drained, and shows on out_valid from there.
// Throughput: one input beat per clock while in_ready is high, limited by the
// single read-or-write port of the line buffer, which serves one beat per cycle.
// Reset: rst_n is synchronous; it returns the block to loading with an empty
// buffer and both registers at 1. The buffer itself is not cleared.
// Stall: when out_ready is low the output register holds its beat, one more
// result may wait in the read stage, and then in_ready drops.
// ----------------------------------------------------------------------------
module integer_pixel_upscaler_unit
  import ipu_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_item,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_item,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // Configuration registers.
  logic [SCALE_W-1:0] scale_r;
  logic [WIDTH_W-1:0] width_r;

  // Sequencing state.
  logic [COL_W-1:0]   fill_r, fill_nxt;
  logic               emit_r, emit_nxt;
  logic [COL_W-1:0]   col_r, col_nxt;
  logic [SCALE_W-1:0] hrep_r, hrep_nxt;
  logic [SCALE_W-1:0] vrep_r, vrep_nxt;
  logic [PAD_W-1:0]   pad_r, pad_nxt;

  // Read stage and output register.
  logic               p_valid_r, p_valid_nxt;
  res_meta_t          p_meta_r;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_item_r;

  // Line buffer.
  logic [PIX_W-1:0]   mem [MAX_ROW_PIXELS];
  logic [PIX_W-1:0]   rdata_r;

  logic               acc, adv;
  logic               wr_en, rd_en;
  logic               res_vld;
  res_meta_t          res_meta;
  logic [SCALE_W-1:0] s_eff;
  logic [WIDTH_W-1:0] w_eff;
  logic [PAD_W-1:0]   row_bytes_lo;
  logic [PAD_W-1:0]   pads;
  logic [COL_W:0]     col_inc;
  logic [SCALE_W:0]   h_inc;
  logic [SCALE_W:0]   v_inc;
  logic [PAD_W:0]     pad_inc;
  logic               last_pix;
  logic               finish;

  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // The pipeline moves when the output register is empty or being drained.
  assign adv      = !out_valid_r || out_ready;
  assign in_ready = !p_valid_r || adv;
  assign acc      = in_valid && in_ready;

  // Out-of-range register values are clamped into the legal range.
  always_comb begin
    if (scale_r == '0) begin
      s_eff = SCALE_W'(1);
    end else if (scale_r > SCALE_W'(MAX_SCALE)) begin
      s_eff = SCALE_W'(MAX_SCALE);
    end else begin
      s_eff = scale_r;
    end
    if (width_r == '0) begin
      w_eff = WIDTH_W'(1);
    end else if (width_r > WIDTH_W'(MAX_ROW_PIXELS)) begin
      w_eff = WIDTH_W'(MAX_ROW_PIXELS);
    end else begin
      w_eff = width_r;
    end
  end

  // Only the low bits of W*S*3 decide how many pad bytes close a row.
  assign row_bytes_lo = PAD_W'(w_eff[PAD_W-1:0] * s_eff[PAD_W-1:0] * 2'd3);
  assign pads         = PAD_W'(-row_bytes_lo);

  always_comb begin
    fill_nxt = fill_r;
    emit_nxt = emit_r;
    col_nxt  = col_r;
    hrep_nxt = hrep_r;
    vrep_nxt = vrep_r;
    pad_nxt  = pad_r;
    wr_en    = 1'b0;
    rd_en    = 1'b0;
    res_vld  = 1'b0;
    res_meta = '0;
    finish   = 1'b0;
    col_inc  = {1'b0, col_r} + 1'b1;
    h_inc    = {1'b0, hrep_r} + 1'b1;
    v_inc    = {1'b0, vrep_r} + 1'b1;
    pad_inc  = {1'b0, pad_r} + 1'b1;
    last_pix = (col_inc >= (COL_W + 1)'(w_eff)) && (h_inc >= {1'b0, s_eff});
    if (acc) begin
      if (in_item.operation == OP_PIXEL) begin
        if (emit_r) begin
          res_vld       = 1'b1;
          res_meta.kind = KIND_REFUSED;
        end else begin
          wr_en    = 1'b1;
          fill_nxt = fill_r + 1'b1;
          if (fill_nxt >= COL_W'(w_eff)) begin
            emit_nxt = 1'b1;
            col_nxt  = '0;
            hrep_nxt = '0;
            vrep_nxt = '0;
            pad_nxt  = '0;
          end
        end
      end else if (emit_r) begin
        res_vld = 1'b1;
        if (col_r < COL_W'(w_eff)) begin
          rd_en            = 1'b1;
          res_meta.kind    = KIND_PIXEL;
          res_meta.use_mem = 1'b1;
          if (h_inc >= {1'b0, s_eff}) begin
            hrep_nxt = '0;
            col_nxt  = col_inc[COL_W-1:0];
          end else begin
            hrep_nxt = h_inc[SCALE_W-1:0];
          end
          if (last_pix) begin
            col_nxt = COL_W'(w_eff);
            finish  = (pads == '0);
          end
        end else begin
          res_meta.kind = KIND_PAD;
          if (pad_inc >= {1'b0, pads}) begin
            finish = 1'b1;
          end else begin
            pad_nxt = pad_inc[PAD_W-1:0];
          end
        end
        // Closing a row: restart the columns, count the copy and leave
        // emission after the last copy.
        if (finish) begin
          res_meta.row_end = 1'b1;
          col_nxt  = '0;
          hrep_nxt = '0;
          pad_nxt  = '0;
          if (v_inc >= {1'b0, s_eff}) begin
            res_meta.expansion_end = 1'b1;
            vrep_nxt = '0;
            emit_nxt = 1'b0;
            fill_nxt = '0;
          end else begin
            vrep_nxt = v_inc[SCALE_W-1:0];
          end
        end
      end
    end
  end

  always_comb begin
    if (acc) begin
      p_valid_nxt = res_vld;
    end else if (adv) begin
      p_valid_nxt = 1'b0;
    end else begin
      p_valid_nxt = p_valid_r;
    end
    out_valid_nxt = adv ? p_valid_r : out_valid_r;
  end

  // Line buffer: one write or one read per cycle, read data registered.
  // A read never targets the entry written in the same cycle, since both
  // come from the one beat accepted in that cycle.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[fill_r[ADDR_W-1:0]] <= {in_item.red_in, in_item.green_in, in_item.blue_in};
    end
    if (rd_en) begin
      rdata_r <= mem[col_r[ADDR_W-1:0]];
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (acc) begin
      p_meta_r <= res_meta;
    end
    if (adv && p_valid_r) begin
      out_item_r.kind          <= p_meta_r.kind;
      out_item_r.row_end       <= p_meta_r.row_end;
      out_item_r.expansion_end <= p_meta_r.expansion_end;
      if (p_meta_r.use_mem) begin
        out_item_r.red_out   <= rdata_r[23:16];
        out_item_r.green_out <= rdata_r[15:8];
        out_item_r.blue_out  <= rdata_r[7:0];
      end else begin
        out_item_r.red_out   <= '0;
        out_item_r.green_out <= '0;
        out_item_r.blue_out  <= '0;
      end
    end
  end

  // Control state and configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r     <= SCALE_W'(1);
      width_r     <= WIDTH_W'(1);
      fill_r      <= '0;
      emit_r      <= 1'b0;
      col_r       <= '0;
      hrep_r      <= '0;
      vrep_r      <= '0;
      pad_r       <= '0;
      p_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (reg_idx_t'(cfg_index))
          REG_SCALE_FACTOR: scale_r <= cfg_data[SCALE_W-1:0];
          REG_ROW_WIDTH:    width_r <= cfg_data[WIDTH_W-1:0];
          default: ;
        endcase
      end
      fill_r      <= fill_nxt;
      emit_r      <= emit_nxt;
      col_r       <= col_nxt;
      hrep_r      <= hrep_nxt;
      vrep_r      <= vrep_nxt;
      pad_r       <= pad_nxt;
      p_valid_r   <= p_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

### hdl/ipu_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Integer pixel upscaler port checker
// Watches the result channel of the upscaler and is bound to its top level.
// ----------------------------------------------------------------------------
`include "integer_pixel_upscaler_unit_macros.svh"

module ipu_checker
  import ipu_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_item
);

  `IPU_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
                   out_valid && $stable(out_item), "stalled result beat changed")
  `IPU_ASSERT_SAME(a_refused_clean, out_valid && out_item.kind == KIND_REFUSED,
                   out_item.blue_out == 8'd0 && out_item.green_out == 8'd0 &&
                   out_item.red_out == 8'd0 && !out_item.row_end &&
                   !out_item.expansion_end, "refused beat carries data or markers")
  `IPU_ASSERT_SAME(a_pad_zero, out_valid && out_item.kind == KIND_PAD,
                   out_item.blue_out == 8'd0 && out_item.green_out == 8'd0 &&
                   out_item.red_out == 8'd0, "pad beat is not zero")
  `IPU_ASSERT_SAME(a_exp_end_row, out_valid && out_item.expansion_end,
                   out_item.row_end, "expansion end without row end")

endmodule

bind integer_pixel_upscaler_unit ipu_checker u_ipu_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item)
);
